// File: rtl/core/gbn_pkg.sv
// Shared types and constants of the Go-Back-N ARQ engine.
package gbn_pkg;

	localparam int SEQ_W = 3;

	typedef logic [SEQ_W-1:0] seq_t;
	typedef logic [1:0]       func_t;
	typedef logic [1:0]       kind_t;

	// item codes on the command channel
	localparam func_t FUNC_LINK   = 2'd0;
	localparam func_t FUNC_PACKET = 2'd1;
	localparam func_t FUNC_TICK   = 2'd2;

	// result codes on the result channel
	localparam kind_t KIND_FRAME   = 2'd0;
	localparam kind_t KIND_DELIVER = 2'd1;
	localparam kind_t KIND_REFUSE  = 2'd2;

	// largest number of unacknowledged frames
	localparam seq_t MAX_OUT = 3'd7;

	localparam logic [15:0] TIMEOUT_RESET = 16'd5000;

	// per-cycle control of the frame store
	typedef struct packed {
		logic buf_we;
		logic time_we;
		seq_t waddr;
		seq_t raddr;
	} gbn_mem_ctl_t;

endpackage

// File: rtl/core/gbn_if.sv
// Valid/ready channel interfaces for commands and results.
interface gbn_in_if
	import gbn_pkg::*;
	();
	logic        valid;
	logic        ready;
	func_t       func;
	seq_t        rx_seq;
	seq_t        rx_ack;
	logic [63:0] payload;

	modport source (output valid, func, rx_seq, rx_ack, payload, input ready);
	modport sink   (input valid, func, rx_seq, rx_ack, payload, output ready);
endinterface

interface gbn_out_if
	import gbn_pkg::*;
	();
	logic        valid;
	logic        ready;
	kind_t       kind;
	seq_t        tx_seq;
	seq_t        tx_ack;
	logic [63:0] out_payload;
	logic        last;
	seq_t        outstanding;
	logic        accepting;

	modport source (output valid, kind, tx_seq, tx_ack, out_payload, last, outstanding,
		accepting, input ready);
	modport sink   (input valid, kind, tx_seq, tx_ack, out_payload, last, outstanding,
		accepting, output ready);
endinterface

// File: rtl/core/gbn_store.sv
// Frame store: payload and send-time memories, one write and one registered read each.
module gbn_store
	import gbn_pkg::*;
#(
	parameter int PAY_W  = 64,
	parameter int TIME_W = 32
) (
	input  logic              clk,
	input  gbn_mem_ctl_t      ctl,
	input  logic [PAY_W-1:0]  wbuf,
	input  logic [TIME_W-1:0] wtime,
	output logic [PAY_W-1:0]  rbuf,
	output logic [TIME_W-1:0] rtime
);

	localparam int DEPTH = 1 << SEQ_W;

	logic [PAY_W-1:0]  buf_mem [DEPTH];
	logic [TIME_W-1:0] time_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.buf_we) begin
			buf_mem[ctl.waddr] <= wbuf;
		end
		rbuf <= buf_mem[ctl.raddr];
	end

	always_ff @(posedge clk) begin
		if (ctl.time_we) begin
			time_mem[ctl.waddr] <= wtime;
		end
		rtime <= time_mem[ctl.raddr];
	end

endmodule

// File: rtl/core/gbn_ctrl.sv
// Sequencer: window state, timer, command decode and the result register.
module gbn_ctrl
	import gbn_pkg::*;
#(
	parameter int PAY_W  = 64,
	parameter int TIME_W = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_wdata,
	gbn_in_if.sink            cmd,
	gbn_out_if.source         res,
	output gbn_mem_ctl_t      mem_ctl,
	output logic [PAY_W-1:0]  mem_wbuf,
	output logic [TIME_W-1:0] mem_wtime,
	input  logic [PAY_W-1:0]  mem_rbuf,
	input  logic [TIME_W-1:0] mem_rtime
);

	typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_CHECK, ST_SEND} state_t;

	state_t            state_q;
	func_t             func_q;
	seq_t              rx_seq_q;
	seq_t              rx_ack_q;
	logic [PAY_W-1:0]  pay_q;
	seq_t              next_q;
	seq_t              oldest_q;
	seq_t              expect_q;
	seq_t              count_q;
	seq_t              ptr_q;
	seq_t              left_q;
	logic [TIME_W-1:0] time_q;
	logic [15:0]       timeout_q;

	logic              res_valid_q;
	kind_t             kind_q;
	seq_t              tx_seq_q;
	seq_t              tx_ack_q;
	logic [63:0]       res_pay_q;
	logic              last_q;
	seq_t              outst_q;
	logic              acc_q;

	logic              slot_free;
	logic              cmd_fire;
	seq_t              ack_d;
	logic              ack_hit;
	seq_t              count_ack;
	logic              deliver;
	logic              full;
	logic [TIME_W-1:0] elapsed;
	logic              expired;
	logic              send_fire;
	logic              res_load;
	seq_t              ack_out;

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign slot_free = !res_valid_q || res.ready;

	assign ack_d     = rx_ack_q - oldest_q;
	assign ack_hit   = ack_d < count_q;
	assign count_ack = ack_hit ? count_q - ack_d - 3'd1 : count_q;
	assign deliver   = (rx_seq_q == expect_q);
	assign full      = (count_q == MAX_OUT);
	assign elapsed   = time_q - mem_rtime;
	assign expired   = (count_q != '0) && (elapsed > TIME_W'(timeout_q));
	assign send_fire = (state_q == ST_SEND) && slot_free;
	assign ack_out   = expect_q - 3'd1;
	assign res_load  = ((state_q == ST_EXEC) && (func_q != FUNC_LINK || deliver) && slot_free)
		|| send_fire;

	// During a resend, reads run ahead of the resend pointer; writes in a resend only touch send
	// times, so no resend read meets a write to the same payload entry.
	always_comb begin
		mem_ctl.buf_we  = (state_q == ST_EXEC) && (func_q == FUNC_PACKET) && !full
			&& slot_free;
		mem_ctl.time_we = mem_ctl.buf_we || send_fire;
		mem_ctl.waddr   = (state_q == ST_SEND) ? ptr_q : next_q;
		if (state_q == ST_IDLE) begin
			mem_ctl.raddr = oldest_q;
		end else if (send_fire) begin
			mem_ctl.raddr = ptr_q + 3'd1;
		end else begin
			mem_ctl.raddr = ptr_q;
		end
	end
	assign mem_wbuf  = pay_q;
	assign mem_wtime = time_q;

	assign res.valid       = res_valid_q;
	assign res.kind        = kind_q;
	assign res.tx_seq      = tx_seq_q;
	assign res.tx_ack      = tx_ack_q;
	assign res.out_payload = res_pay_q;
	assign res.last        = last_q;
	assign res.outstanding = outst_q;
	assign res.accepting   = acc_q;

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			func_q   <= cmd.func;
			rx_seq_q <= cmd.rx_seq;
			rx_ack_q <= cmd.rx_ack;
			pay_q    <= cmd.payload[PAY_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			next_q      <= '0;
			oldest_q    <= '0;
			expect_q    <= '0;
			count_q     <= '0;
			ptr_q       <= '0;
			left_q      <= '0;
			time_q      <= '0;
			timeout_q   <= TIMEOUT_RESET;
			res_valid_q <= 1'b0;
			kind_q      <= KIND_FRAME;
			tx_seq_q    <= '0;
			tx_ack_q    <= '0;
			res_pay_q   <= '0;
			last_q      <= 1'b0;
			outst_q     <= '0;
			acc_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						ptr_q <= oldest_q;
						unique case (cmd.func)
							FUNC_LINK, FUNC_PACKET: state_q <= ST_EXEC;
							FUNC_TICK: begin
								time_q  <= time_q + 1'b1;
								state_q <= ST_CHECK;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end

				ST_EXEC: begin
					if (func_q == FUNC_LINK) begin
						// the ack is taken even when the frame is out of order
						if (!deliver || slot_free) begin
							oldest_q <= ack_hit ? rx_ack_q + 3'd1 : oldest_q;
							count_q  <= count_ack;
							state_q  <= ST_IDLE;
							if (deliver) begin
								expect_q    <= expect_q + 3'd1;
								kind_q      <= KIND_DELIVER;
								tx_seq_q    <= '0;
								tx_ack_q    <= '0;
								res_pay_q   <= 64'(pay_q);
								last_q      <= 1'b1;
								outst_q     <= count_ack;
								acc_q       <= (count_ack != MAX_OUT);
							end
						end
					end else if (slot_free) begin
						last_q      <= 1'b1;
						state_q     <= ST_IDLE;
						if (full) begin
							kind_q    <= KIND_REFUSE;
							tx_seq_q  <= '0;
							tx_ack_q  <= '0;
							res_pay_q <= '0;
							outst_q   <= count_q;
							acc_q     <= 1'b0;
						end else begin
							kind_q    <= KIND_FRAME;
							tx_seq_q  <= next_q;
							tx_ack_q  <= ack_out;
							res_pay_q <= 64'(pay_q);
							outst_q   <= count_q + 3'd1;
							acc_q     <= (count_q + 3'd1 != MAX_OUT);
							next_q    <= next_q + 3'd1;
							count_q   <= count_q + 3'd1;
						end
					end
				end

				ST_CHECK: begin
					left_q  <= count_q;
					state_q <= expired ? ST_SEND : ST_IDLE;
				end

				ST_SEND: begin
					if (slot_free) begin
						kind_q      <= KIND_FRAME;
						tx_seq_q    <= ptr_q;
						tx_ack_q    <= ack_out;
						res_pay_q   <= 64'(mem_rbuf);
						last_q      <= (left_q == 3'd1);
						outst_q     <= count_q;
						acc_q       <= !full;
						ptr_q       <= ptr_q + 3'd1;
						left_q      <= left_q - 3'd1;
						if (left_q == 3'd1) begin
							next_q  <= ptr_q + 3'd1;
							state_q <= ST_IDLE;
						end
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/core/go_back_n_arq_engine_unit.sv
// Top level of the Go-Back-N ARQ engine.
//
// Channels: cmd carries one item per transaction (frame from the link, packet from the
// upper layer, or time tick); res carries result transactions (data frame to the link,
// payload delivered upstream, or packet refused). last marks the final result of an item.
// cfg_we/cfg_wdata write the timeout in ticks; write it only while the block is idle.
// A link frame or packet is taken into the sequencer, decoded in the execute state and its
// result loaded into the result register. A tick that expires the oldest frame passes the
// check state and then resends every outstanding frame (up to seven); the single result
// register emits one result per cycle while res is ready, each payload read registered from
// the frame store. The sequencer takes a command only when idle, after the last item is done.
// A stale frame or unexpired tick yields nothing yet still passes the execute or check state.
// Reset: sequence numbers, window count and time clear to zero, timeout to 5000 ticks;
// the frame store is not cleared and needs no sweep.
// Stall: a result waits in the output register; a new command is still taken, but the
// sequencer holds before the next result until the register is free.
module go_back_n_arq_engine_unit
	import gbn_pkg::*;
#(
	parameter int PAYLOAD_BYTES = 8,
	parameter int TIME_BITS     = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	gbn_in_if.sink      cmd,
	gbn_out_if.source   res
);

	localparam int PAY_W = PAYLOAD_BYTES * 8;

	gbn_mem_ctl_t         mem_ctl;
	logic [PAY_W-1:0]     mem_wbuf;
	logic [TIME_BITS-1:0] mem_wtime;
	logic [PAY_W-1:0]     mem_rbuf;
	logic [TIME_BITS-1:0] mem_rtime;

	gbn_ctrl #(
		.PAY_W  (PAY_W),
		.TIME_W (TIME_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.res       (res),
		.mem_ctl   (mem_ctl),
		.mem_wbuf  (mem_wbuf),
		.mem_wtime (mem_wtime),
		.mem_rbuf  (mem_rbuf),
		.mem_rtime (mem_rtime)
	);

	gbn_store #(
		.PAY_W  (PAY_W),
		.TIME_W (TIME_BITS)
	) u_store (
		.clk   (clk),
		.ctl   (mem_ctl),
		.wbuf  (mem_wbuf),
		.wtime (mem_wtime),
		.rbuf  (mem_rbuf),
		.rtime (mem_rtime)
	);

endmodule
